[hw/rtl/gtpd_pkg.sv]
// Shared constants, types and helper functions for the gyro to pointer delta block.
package gtpd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = 16;
  localparam int RES_BITS      = 40;
  localparam int ACC_BITS      = RES_BITS + 1;
  localparam int INT_BITS      = RES_BITS - FRAC_BITS;
  localparam int DIVISOR_BITS  = 16;
  localparam int QUOT_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int DIV_STEPS     = QUOT_BITS / 2;
  localparam int STEP_CNT_BITS = $clog2(DIV_STEPS);
  localparam int DELTA_BITS    = 8;
  localparam int STEP_LIMIT    = 126;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SENS_X   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SENS_Y   = 2'd3;

  localparam logic [CFG_DATA_BITS-1:0] CENTRE_RESET = 16'd32768;
  localparam logic [CFG_DATA_BITS-1:0] SENS_RESET   = 16'd400;

  typedef struct packed {
    logic                    neg;
    logic [SAMPLE_BITS-1:0]  mag;
  } offset_t;

  typedef struct packed {
    logic                    start;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [DIVISOR_BITS-1:0] divisor;
  } div_req_t;

  function automatic offset_t axis_offset(input logic [SAMPLE_BITS-1:0] sample,
                                          input logic [SAMPLE_BITS-1:0] centre);
    logic [SAMPLE_BITS:0] d;
    logic [SAMPLE_BITS:0] m;
    offset_t              o;
    d     = {1'b0, centre} - {1'b0, sample};
    m     = d[SAMPLE_BITS] ? (~d + 1'b1) : d;
    o.neg = d[SAMPLE_BITS];
    o.mag = m[SAMPLE_BITS-1:0];
    return o;
  endfunction

  function automatic logic [DIVISOR_BITS-1:0] safe_divisor(input logic [DIVISOR_BITS-1:0] s);
    return (s == '0) ? DIVISOR_BITS'(1) : s;
  endfunction

  function automatic logic [RES_BITS-1:0] sat_res(input logic [ACC_BITS-1:0] v);
    logic [RES_BITS-1:0] r;
    if (v[ACC_BITS-1] == v[ACC_BITS-2]) begin
      r = v[RES_BITS-1:0];
    end else if (v[ACC_BITS-1]) begin
      r = {1'b1, {(RES_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(RES_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[hw/rtl/gtpd_div.sv]
// Iterative restoring divider that retires two quotient bits per cycle.
module gtpd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  gtpd_pkg::div_req_t            req,
  output logic                          done,
  output logic [gtpd_pkg::QUOT_BITS-1:0] quotient
);

  localparam int QB = gtpd_pkg::QUOT_BITS;
  localparam int DB = gtpd_pkg::DIVISOR_BITS;
  localparam logic [gtpd_pkg::STEP_CNT_BITS-1:0] LAST_STEP =
    gtpd_pkg::STEP_CNT_BITS'(gtpd_pkg::DIV_STEPS - 1);

  logic                               busy;
  logic [gtpd_pkg::STEP_CNT_BITS-1:0] cnt;
  logic [DB-1:0]                      rem;
  logic [DB-1:0]                      divisor;
  logic [QB-1:0]                      work;

  logic [DB:0]   t1;
  logic [DB:0]   t2;
  logic          ge1;
  logic          ge2;
  logic [DB-1:0] r1;
  logic [DB-1:0] r2;
  logic [DB:0]   d1;
  logic [DB:0]   d2;
  logic [QB-1:0] work_next;

  always_comb begin
    t1        = {rem, work[QB-1]};
    ge1       = t1 >= {1'b0, divisor};
    d1        = t1 - {1'b0, divisor};
    r1        = ge1 ? d1[DB-1:0] : t1[DB-1:0];
    t2        = {r1, work[QB-2]};
    ge2       = t2 >= {1'b0, divisor};
    d2        = t2 - {1'b0, divisor};
    r2        = ge2 ? d2[DB-1:0] : t2[DB-1:0];
    work_next = {work[QB-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        divisor <= req.divisor;
        work    <= {req.mag, {gtpd_pkg::FRAC_BITS{1'b0}}};
      end else if (busy) begin
        work <= work_next;
        rem  <= r2;
        cnt  <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = work;

endmodule

[hw/rtl/gtpd_accum.sv]
// Residual accumulation, integer extraction with clamp, and residual update for one axis.
module gtpd_accum (
  input  logic [gtpd_pkg::RES_BITS-1:0]   residual,
  input  logic [gtpd_pkg::QUOT_BITS-1:0]  quot,
  input  logic                            neg,
  output logic [gtpd_pkg::DELTA_BITS-1:0] emit,
  output logic [gtpd_pkg::RES_BITS-1:0]   residual_next
);

  localparam int AB = gtpd_pkg::ACC_BITS;
  localparam int RB = gtpd_pkg::RES_BITS;
  localparam int EB = gtpd_pkg::DELTA_BITS;

  logic [AB-1:0]                     q_ext;
  logic [AB-1:0]                     q_s;
  logic [AB-1:0]                     sum;
  logic [RB-1:0]                     acc;
  logic                              aneg;
  logic [AB-1:0]                     acc_ext;
  logic [AB-1:0]                     amag;
  logic [gtpd_pkg::INT_BITS-1:0]     imag;
  logic [EB-1:0]                     imag_c;
  logic [AB-1:0]                     emit_ext;
  logic [AB-1:0]                     rest;

  always_comb begin
    q_ext    = {{(AB-gtpd_pkg::QUOT_BITS){1'b0}}, quot};
    q_s      = neg ? (~q_ext + 1'b1) : q_ext;
    sum      = {residual[RB-1], residual} + q_s;
    acc      = gtpd_pkg::sat_res(sum);
    aneg     = acc[RB-1];
    acc_ext  = {acc[RB-1], acc};
    amag     = aneg ? (~acc_ext + 1'b1) : acc_ext;
    imag     = amag[RB-1:gtpd_pkg::FRAC_BITS];
    if (imag > gtpd_pkg::INT_BITS'(gtpd_pkg::STEP_LIMIT)) begin
      imag_c = EB'(gtpd_pkg::STEP_LIMIT);
    end else begin
      imag_c = imag[EB-1:0];
    end
    emit     = aneg ? (~imag_c + 1'b1) : imag_c;
    emit_ext = {{(AB-EB){emit[EB-1]}}, emit};
    rest     = acc_ext - (emit_ext << gtpd_pkg::FRAC_BITS);
    residual_next = gtpd_pkg::sat_res(rest);
  end

endmodule

[hw/rtl/gyro_to_pointer_delta.sv]
// Top level of the gyro to pointer delta converter: registers, sequencer and output stage.
//
//   Channel | Signals                                   | Direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, gyro_x/y_sample       | input item
//   out     | out_valid, out_ready, delta_x, delta_y    | result item
//   cfg     | cfg_wr_en, cfg_index, cfg_data            | register write
//
// Each axis occupies the divider for one load and 16 steps at two quotient bits each.
// The x and y axes run one after the other through the divider and accumulator.
// The result sits in an output register, so a new item is taken while it waits.
// A second result waits in the push state until the output register is free.
// Reset is synchronous and restores the register defaults and clears both residuals.
module gyro_to_pointer_delta (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gtpd_pkg::SAMPLE_BITS-1:0]     gyro_x_sample,
  input  logic [gtpd_pkg::SAMPLE_BITS-1:0]     gyro_y_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [gtpd_pkg::DELTA_BITS-1:0] delta_x,
  output logic signed [gtpd_pkg::DELTA_BITS-1:0] delta_y,
  input  logic                                 cfg_wr_en,
  input  logic [gtpd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gtpd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_PUSH
  } state_t;

  state_t state;

  logic [gtpd_pkg::CFG_DATA_BITS-1:0] centre_x;
  logic [gtpd_pkg::CFG_DATA_BITS-1:0] centre_y;
  logic [gtpd_pkg::CFG_DATA_BITS-1:0] sensitivity_x;
  logic [gtpd_pkg::CFG_DATA_BITS-1:0] sensitivity_y;
  logic [gtpd_pkg::RES_BITS-1:0]      residual_x;
  logic [gtpd_pkg::RES_BITS-1:0]      residual_y;

  logic                               neg_x;
  logic                               neg_y;
  logic [gtpd_pkg::SAMPLE_BITS-1:0]   mag_y;
  logic [gtpd_pkg::DELTA_BITS-1:0]    dx;
  logic [gtpd_pkg::DELTA_BITS-1:0]    dy;

  gtpd_pkg::offset_t                  off_x;
  gtpd_pkg::offset_t                  off_y;
  gtpd_pkg::div_req_t                 div_req;
  logic                               div_done;
  logic [gtpd_pkg::QUOT_BITS-1:0]     quot;
  logic                               in_accept;
  logic                               out_free;

  logic [gtpd_pkg::RES_BITS-1:0]      acc_res;
  logic                               acc_neg;
  logic [gtpd_pkg::DELTA_BITS-1:0]    emit;
  logic [gtpd_pkg::RES_BITS-1:0]      res_next;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    off_x = gtpd_pkg::axis_offset(gyro_x_sample, centre_x);
    off_y = gtpd_pkg::axis_offset(gyro_y_sample, centre_y);
    div_req.start = in_accept || ((state == S_DIV_X) && div_done);
    if (state == S_IDLE) begin
      div_req.mag     = off_x.mag;
      div_req.divisor = gtpd_pkg::safe_divisor(sensitivity_x);
    end else begin
      div_req.mag     = mag_y;
      div_req.divisor = gtpd_pkg::safe_divisor(sensitivity_y);
    end
    acc_res = (state == S_DIV_X) ? residual_x : residual_y;
    acc_neg = (state == S_DIV_X) ? neg_x : neg_y;
  end

  gtpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quot)
  );

  gtpd_accum u_accum (
    .residual      (acc_res),
    .quot          (quot),
    .neg           (acc_neg),
    .emit          (emit),
    .residual_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x      <= gtpd_pkg::CENTRE_RESET;
      centre_y      <= gtpd_pkg::CENTRE_RESET;
      sensitivity_x <= gtpd_pkg::SENS_RESET;
      sensitivity_y <= gtpd_pkg::SENS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gtpd_pkg::REG_CENTRE_X: centre_x      <= cfg_data;
        gtpd_pkg::REG_CENTRE_Y: centre_y      <= cfg_data;
        gtpd_pkg::REG_SENS_X:   sensitivity_x <= cfg_data;
        gtpd_pkg::REG_SENS_Y:   sensitivity_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      residual_x <= '0;
      residual_y <= '0;
    end else begin
      if ((state == S_PUSH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            neg_x <= off_x.neg;
            neg_y <= off_y.neg;
            mag_y <= off_y.mag;
            state <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            residual_x <= res_next;
            dx         <= emit;
            state      <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_done) begin
            residual_y <= res_next;
            dy         <= emit;
            state      <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            delta_x <= dx;
            delta_y <= dy;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/gtpd_checker.sv]
// Port-level checker for the gyro to pointer delta block, bound to the top level.
module gtpd_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [gtpd_pkg::DELTA_BITS-1:0] delta_x,
  input logic signed [gtpd_pkg::DELTA_BITS-1:0] delta_y
);

  localparam logic signed [gtpd_pkg::DELTA_BITS-1:0] LIM_POS =
    gtpd_pkg::DELTA_BITS'(gtpd_pkg::STEP_LIMIT);
  localparam logic signed [gtpd_pkg::DELTA_BITS-1:0] LIM_NEG =
    gtpd_pkg::DELTA_BITS'(-gtpd_pkg::STEP_LIMIT);

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Block not empty after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("Input taken again while an item is in progress.");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> delta_x <= LIM_POS && delta_x >= LIM_NEG &&
                  delta_y <= LIM_POS && delta_y >= LIM_NEG)
    else $error("Delta outside the clamp range.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(delta_x) && $stable(delta_y))
    else $error("Result changed while stalled.");

endmodule

bind gyro_to_pointer_delta gtpd_checker u_gtpd_checker (.*);
